### src/tgq_pkg.sv
package tgq_pkg;

	localparam int unsigned CfgW = 16;
	localparam int unsigned CfgIdxW = 2;
	localparam int unsigned TimeW = 32;
	localparam int unsigned PosW = 12;
	localparam int unsigned EvW = 3;
	localparam int unsigned InDataW = 80;
	localparam int unsigned OutDataW = 32;

	localparam logic [CfgIdxW-1:0] REG_IGNORE = 2'd0;
	localparam logic [CfgIdxW-1:0] REG_SHORT_HOLD = 2'd1;
	localparam logic [CfgIdxW-1:0] REG_LONG_HOLD = 2'd2;

	localparam logic [CfgW-1:0] IGNORE_RST = 16'd50;
	localparam logic [CfgW-1:0] SHORT_HOLD_RST = 16'd1500;
	localparam logic [CfgW-1:0] LONG_HOLD_RST = 16'd3000;

	localparam logic [7:0] NIBBLE_MASK = 8'h0F;

	localparam logic [EvW-1:0] EV_NONE = 3'd0;
	localparam logic [EvW-1:0] EV_LONG = 3'd1;
	localparam logic [EvW-1:0] EV_SHORT = 3'd2;
	localparam logic [EvW-1:0] EV_DTAP = 3'd3;
	localparam logic [EvW-1:0] EV_UP = 3'd4;
	localparam logic [EvW-1:0] EV_DOWN = 3'd5;
	localparam logic [EvW-1:0] EV_LEFT = 3'd6;
	localparam logic [EvW-1:0] EV_RIGHT = 3'd7;

	localparam logic [7:0] GC_NONE = 8'h00;
	localparam logic [7:0] GC_UP = 8'h01;
	localparam logic [7:0] GC_DOWN = 8'h02;
	localparam logic [7:0] GC_LEFT = 8'h03;
	localparam logic [7:0] GC_RIGHT = 8'h04;
	localparam logic [7:0] GC_DTAP = 8'h0B;

	typedef struct packed {
		logic [7:0] y_low;
		logic [7:0] y_high;
		logic [7:0] x_low;
		logic [7:0] x_high;
		logic [TimeW-1:0] now_ms;
		logic [7:0] gesture_code;
		logic [7:0] finger_count;
	} poll_t;

	typedef struct packed {
		logic [PosW-1:0] y_pos;
		logic [PosW-1:0] x_pos;
		logic is_touching;
		logic [EvW-1:0] event_res;
	} res_t;

	typedef struct packed {
		logic [CfgW-1:0] ignore_ms;
		logic [CfgW-1:0] short_hold_ms;
		logic [CfgW-1:0] long_hold_ms;
	} thr_t;

	function automatic logic [EvW-1:0] map_gesture(input logic [7:0] code);
		logic [EvW-1:0] ev;
		case (code)
			GC_UP: ev = EV_UP;
			GC_DOWN: ev = EV_DOWN;
			GC_LEFT: ev = EV_LEFT;
			GC_RIGHT: ev = EV_RIGHT;
			GC_DTAP: ev = EV_DTAP;
			default: ev = EV_NONE;
		endcase
		return ev;
	endfunction

endpackage

### src/tgq_core.sv
module tgq_core (
	input logic clk,
	input logic arst_n,
	input logic advance,
	input tgq_pkg::poll_t poll,
	input tgq_pkg::thr_t thr,
	output tgq_pkg::res_t res
);

	logic pressed_q;
	logic [tgq_pkg::TimeW-1:0] press_start_q;
	logic short_done_q;
	logic long_done_q;
	logic [7:0] prev_gesture_q;
	logic gesture_used_q;

	logic touch;
	logic code_nz;
	logic fresh;
	logic used_a;
	logic rise;
	logic fall;
	logic [tgq_pkg::TimeW-1:0] start_a;
	logic short_a;
	logic long_a;
	logic [tgq_pkg::TimeW-1:0] hold;
	logic phantom;
	logic long_fire;
	logic short_fire;
	logic gest_fire;
	logic short_n;
	logic long_n;
	logic used_n;
	logic [tgq_pkg::EvW-1:0] ev;

	always_comb begin
		touch = (poll.finger_count != 8'd0);
		code_nz = (poll.gesture_code != tgq_pkg::GC_NONE);
		fresh = code_nz && (poll.gesture_code != prev_gesture_q);
		// a new code, or a return to none, rearms the gesture report
		if (fresh || (!code_nz && (prev_gesture_q != tgq_pkg::GC_NONE))) begin
			used_a = 1'b0;
		end else begin
			used_a = gesture_used_q;
		end
		rise = touch && !pressed_q;
		fall = !touch && pressed_q;
		start_a = rise ? poll.now_ms : press_start_q;
		short_a = rise ? 1'b0 : short_done_q;
		long_a = rise ? 1'b0 : long_done_q;
		hold = poll.now_ms - start_a;
		phantom = fall && (hold < {{(tgq_pkg::TimeW-tgq_pkg::CfgW){1'b0}}, thr.ignore_ms});
		long_fire = touch && !long_a
			&& (hold >= {{(tgq_pkg::TimeW-tgq_pkg::CfgW){1'b0}}, thr.long_hold_ms});
		short_fire = touch && !long_fire && !short_a
			&& (hold >= {{(tgq_pkg::TimeW-tgq_pkg::CfgW){1'b0}}, thr.short_hold_ms});
		gest_fire = !phantom && !long_fire && !short_fire && fresh && !used_a;
		short_n = short_a || long_fire || short_fire;
		long_n = long_a || long_fire;
		used_n = used_a || gest_fire;
		if (phantom) begin
			ev = tgq_pkg::EV_NONE;
		end else if (long_fire) begin
			ev = tgq_pkg::EV_LONG;
		end else if (short_fire) begin
			ev = tgq_pkg::EV_SHORT;
		end else if (gest_fire) begin
			ev = tgq_pkg::map_gesture(poll.gesture_code);
		end else begin
			ev = tgq_pkg::EV_NONE;
		end
		res.event_res = ev;
		res.is_touching = touch;
		res.x_pos = {poll.x_high[3:0] & tgq_pkg::NIBBLE_MASK[3:0], poll.x_low};
		res.y_pos = {poll.y_high[3:0] & tgq_pkg::NIBBLE_MASK[3:0], poll.y_low};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pressed_q <= 1'b0;
			press_start_q <= '0;
			short_done_q <= 1'b0;
			long_done_q <= 1'b0;
			prev_gesture_q <= tgq_pkg::GC_NONE;
			gesture_used_q <= 1'b0;
		end else if (advance) begin
			pressed_q <= touch;
			press_start_q <= start_a;
			short_done_q <= short_n;
			long_done_q <= long_n;
			prev_gesture_q <= poll.gesture_code;
			gesture_used_q <= used_n;
		end
	end

`ifndef SYNTHESIS
	a_long_sets_both: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && res.event_res == tgq_pkg::EV_LONG) |=> (long_done_q && short_done_q))
		else $error("long hold event did not set both done flags");

	a_press_start: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && rise) |=> (pressed_q && press_start_q == $past(poll.now_ms)))
		else $error("press start not captured");

	a_gesture_consumed: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && res.event_res >= tgq_pkg::EV_DTAP) |=> gesture_used_q)
		else $error("reported gesture not marked used");
`endif

endmodule

### src/touch_gesture_qualifier.sv
// An accepted poll passes through the input register and then the result register
// before its result shows on the master side.
// Throughput: one poll per cycle; the tracking state updates in a single pass.
// A stalled master side holds the result register and backs up into the input register.
// Reset (arst_n low, asynchronous): tracking state clears, thresholds return to
// 50 / 1500 / 3000 ms, both stages empty.
module touch_gesture_qualifier (
	input logic clk,
	input logic arst_n,
	// poll in
	input logic s_axis_tvalid,
	output logic s_axis_tready,
	// finger_count[7:0], gesture_code[15:8], now_ms[47:16], x_high[55:48],
	// x_low[63:56], y_high[71:64], y_low[79:72]
	input logic [tgq_pkg::InDataW-1:0] s_axis_tdata,
	// result out
	output logic m_axis_tvalid,
	input logic m_axis_tready,
	// event_res[2:0], is_touching[3], x_pos[15:4], y_pos[27:16], zero [31:28]
	output logic [tgq_pkg::OutDataW-1:0] m_axis_tdata,
	// threshold writes
	input logic cfg_we,
	input logic [tgq_pkg::CfgIdxW-1:0] cfg_index,
	input logic [tgq_pkg::CfgW-1:0] cfg_data
);

	tgq_pkg::thr_t thr_q;

	logic valid_s1;
	tgq_pkg::poll_t poll_s1;
	logic out_valid_q;
	tgq_pkg::res_t out_q;
	tgq_pkg::res_t res;
	logic advance;

	// Threshold registers; writes to an unused index are dropped.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q.ignore_ms <= tgq_pkg::IGNORE_RST;
			thr_q.short_hold_ms <= tgq_pkg::SHORT_HOLD_RST;
			thr_q.long_hold_ms <= tgq_pkg::LONG_HOLD_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				tgq_pkg::REG_IGNORE: thr_q.ignore_ms <= cfg_data;
				tgq_pkg::REG_SHORT_HOLD: thr_q.short_hold_ms <= cfg_data;
				tgq_pkg::REG_LONG_HOLD: thr_q.long_hold_ms <= cfg_data;
				default: ;
			endcase
		end
	end

	// Advance the poll in the input register whenever the result register is
	// free or its content is being transferred out this cycle.
	assign advance = valid_s1 && (!out_valid_q || m_axis_tready);
	assign s_axis_tready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tready && s_axis_tvalid) begin
			poll_s1 <= tgq_pkg::poll_t'(s_axis_tdata);
		end
	end

	tgq_core u_core (
		.clk(clk),
		.arst_n(arst_n),
		.advance(advance),
		.poll(poll_s1),
		.thr(thr_q),
		.res(res)
	);

	// Result register: load on advance, drop once the master side takes it.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			out_q <= res;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata = {{(tgq_pkg::OutDataW - $bits(tgq_pkg::res_t)){1'b0}}, out_q};

`ifndef SYNTHESIS
	a_advance_loads: assert property (@(posedge clk) disable iff (!arst_n)
		advance |=> m_axis_tvalid)
		else $error("advanced poll produced no result");

	a_stall_only_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		!s_axis_tready |-> (valid_s1 && out_valid_q && !m_axis_tready))
		else $error("input stalled while a stage was free");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !m_axis_tready) |-> !advance)
		else $error("pending result overwritten");
`endif

endmodule
